### rtl/rgbc3_pkg.sv
// ----------------------------------------------------------------------------
// rgbc3_pkg: shared types and constants of the 3x3 rgb convolution
// Geometry limits, pixel and coefficient types, cell control and
// configuration register indices.
// ----------------------------------------------------------------------------
package rgbc3_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;

  localparam int ColW    = $clog2(MaxWidth);
  localparam int RowW    = $clog2(MaxHeight);
  localparam int WDimW   = ColW + 1;
  localparam int HDimW   = RowW + 1;
  localparam int NumCh   = 3;
  localparam int NumRows = 3;
  localparam int PixW    = 8;
  localparam int CoefW   = 16;
  localparam int ProdW   = PixW + 1 + CoefW;
  localparam int ColSumW = ProdW + 2;
  localparam int SumW    = 28;
  localparam int PosW    = 10;
  localparam int DimW    = 11;
  localparam int KrowW   = 48;
  localparam int CfgIdxW = 3;

  localparam int WidthRst  = (640 > MaxWidth) ? MaxWidth : 640;
  localparam int HeightRst = (480 > MaxHeight) ? MaxHeight : 480;

  // largest output position that a legal frame can give
  localparam int PosMaxInt = (MaxWidth > MaxHeight) ? MaxWidth - 3 : MaxHeight - 3;
  localparam int PosMax    = (PosMaxInt > (2 ** PosW) - 1) ? (2 ** PosW) - 1 : PosMaxInt;

  // 9 taps of 255 times the most negative coefficient
  localparam int SumBoundInt = NumRows * 3 * 255 * (2 ** (CoefW - 1));

  typedef logic [NumCh-1:0][PixW-1:0] pix_t;     // channel 0 in the low byte

  typedef struct packed {
    pix_t top;
    pix_t mid;
  } line_t;

  typedef pix_t [NumRows-1:0] col_t;              // index 0 is the top row

  typedef logic signed [CoefW-1:0]   coef_t;
  typedef coef_t [NumRows-1:0]       coef_col_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [ColSumW-1:0] colsum_t;
  typedef colsum_t [NumCh-1:0]       colsum_vec_t;

  typedef struct packed {
    logic adv;    // pipeline moves on
    logic shift;  // a new column enters the window
  } cell_ctrl_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 3'd0,
    CfgHeight = 3'd1,
    CfgKrow0  = 3'd2,
    CfgKrow1  = 3'd3,
    CfgKrow2  = 3'd4
  } cfg_idx_e;

endpackage

### rtl/rgbc3_if.sv
// ----------------------------------------------------------------------------
// rgbc3_if: pixel and result channels
// Valid/ready channels carrying one input pixel or one window result.
// ----------------------------------------------------------------------------
interface rgbc3_in_if;
  import rgbc3_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] chan0;
  logic [PixW-1:0] chan1;
  logic [PixW-1:0] chan2;

  modport source (output valid, output chan0, output chan1, output chan2, input ready);
  modport sink   (input valid, input chan0, input chan1, input chan2, output ready);
endinterface

interface rgbc3_out_if;
  import rgbc3_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [SumW-1:0] sum0;
  logic signed [SumW-1:0] sum1;
  logic signed [SumW-1:0] sum2;
  logic [PosW-1:0]        out_row;
  logic [PosW-1:0]        out_col;

  modport source (output valid, output sum0, output sum1, output sum2,
                  output out_row, output out_col, input ready);
  modport sink   (input valid, input sum0, input sum1, input sum2,
                  input out_row, input out_col, output ready);
endinterface

### rtl/rgb_conv3x3_valid.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_valid: 3x3 correlation over an rgb raster stream
// Line store, three window column cells and an adder stage per channel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order and, for every fully covered
// 3x3 window, returns the three channel sums (12 fraction bits) tagged with
// the window's top-left position. A result passes the line store read,
// window shift, multiply, column add and final add before it is loaded
// into the output register. Input ready only drops while a result
// waits in the output register and a second one is due behind it, so the
// rate is one pixel per clock while results are taken and is set by the
// read/write of the line store (one 48-bit entry per column). The line
// store needs no clearing after reset. Write geometry and kernel only
// between frames while the block is idle.
// ----------------------------------------------------------------------------
module rgb_conv3x3_valid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rgbc3_in_if.sink                      in_i,
  rgbc3_out_if.source                   out_o,
  input  logic                          cfg_we_i,
  input  logic [rgbc3_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rgbc3_pkg::KrowW-1:0]   cfg_data_i
);
  import rgbc3_pkg::*;

  // configuration, geometry kept clamped
  logic [WDimW-1:0]            w_q;
  logic [HDimW-1:0]            h_q;
  logic [NumRows-1:0][KrowW-1:0] krow_q;
  logic [DimW-1:0]             dim_in;
  logic [WDimW-1:0]            w_cfg;
  logic [HDimW-1:0]            h_cfg;

  assign dim_in = cfg_data_i[DimW-1:0];

  always_comb begin
    priority if (dim_in < DimW'(3)) begin
      w_cfg = WDimW'(3);
    end else if (int'(dim_in) > MaxWidth) begin
      w_cfg = WDimW'(MaxWidth);
    end else begin
      w_cfg = WDimW'(dim_in);
    end
    priority if (dim_in < DimW'(3)) begin
      h_cfg = HDimW'(3);
    end else if (int'(dim_in) > MaxHeight) begin
      h_cfg = HDimW'(MaxHeight);
    end else begin
      h_cfg = HDimW'(dim_in);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= WDimW'(WidthRst);
      h_q       <= HDimW'(HeightRst);
      krow_q[0] <= '0;
      krow_q[1] <= KrowW'(48'h0000_1000_0000);
      krow_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgWidth:  w_q       <= w_cfg;
        CfgHeight: h_q       <= h_cfg;
        CfgKrow0:  krow_q[0] <= cfg_data_i;
        CfgKrow1:  krow_q[1] <= cfg_data_i;
        CfgKrow2:  krow_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake and pipeline advance
  logic accept, adv, load_out;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;

  assign load_out   = !out_valid_q || out_o.ready;
  assign adv        = !v4_q || load_out;
  assign in_i.ready = adv;
  assign accept     = in_i.valid && adv;

  // raster position
  logic [ColW-1:0]  col_q, col_d, c_start;
  logic [RowW-1:0]  row_q, row_d, r_start;
  logic [HDimW-1:0] r_pre, r_inc;
  logic [WDimW-1:0] c_inc;
  logic             col_ovf;

  always_comb begin
    col_ovf = {1'b0, col_q} >= w_q;
    c_start = col_ovf ? '0 : col_q;
    r_pre   = col_ovf ? {1'b0, row_q} + HDimW'(1) : {1'b0, row_q};
    r_start = (r_pre >= h_q) ? '0 : r_pre[RowW-1:0];
    c_inc   = {1'b0, c_start} + WDimW'(1);
    r_inc   = {1'b0, r_start} + HDimW'(1);
    if (c_inc >= w_q) begin
      col_d = '0;
      row_d = (r_inc >= h_q) ? '0 : r_inc[RowW-1:0];
    end else begin
      col_d = c_inc[ColW-1:0];
      row_d = r_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line store read in flight
  pix_t            pix1_q;
  logic [ColW-1:0] c1_q;
  logic            emit1_q;
  logic [PosW-1:0] orow1_q, ocol1_q;
  line_t           rd_data;
  pix_t            pix_in;

  assign pix_in = {in_i.chan2, in_i.chan1, in_i.chan0};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q  <= pix_in;
      c1_q    <= c_start;
      emit1_q <= (r_start >= RowW'(2)) && (c_start >= ColW'(2));
      orow1_q <= PosW'(r_start - RowW'(2));
      ocol1_q <= PosW'(c_start - ColW'(2));
    end
  end

  rgbc3_linebuf u_linebuf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (c_start),
    .rd_data_o (rd_data),
    .wr_en_i   (adv && v1_q),
    .wr_addr_i (c1_q),
    .wr_data_i ('{top: rd_data.mid, mid: pix1_q})
  );

  // window cells, cell 2 takes the newest column
  cell_ctrl_t          cell_ctrl;
  col_t                new_col;
  col_t                col_link [NumRows];
  colsum_vec_t         colsum [NumRows];
  coef_col_t           coef_col [NumRows];

  assign cell_ctrl.adv   = adv;
  assign cell_ctrl.shift = v1_q;

  always_comb begin
    new_col[0] = rd_data.top;
    new_col[1] = rd_data.mid;
    new_col[2] = pix1_q;
    for (int j = 0; j < NumRows; j++) begin
      for (int r = 0; r < NumRows; r++) begin
        coef_col[j][r] = krow_q[r][CoefW*j +: CoefW];
      end
    end
  end

  for (genvar j = 0; j < NumRows; j++) begin : g_cell
    rgbc3_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .col_i    ((j == NumRows - 1) ? new_col : col_link[(j + 1) % NumRows]),
      .coef_i   (coef_col[j]),
      .col_o    (col_link[j]),
      .colsum_o (colsum[j])
    );
  end

  // position tags travel beside the cell pipeline
  logic [PosW-1:0] orow2_q, ocol2_q, orow3_q, ocol3_q, orow4_q, ocol4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= accept;
      v2_q <= v1_q && emit1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      orow2_q <= orow1_q;
      ocol2_q <= ocol1_q;
      orow3_q <= orow2_q;
      ocol3_q <= ocol2_q;
      orow4_q <= orow3_q;
      ocol4_q <= ocol3_q;
    end
  end

  // output register
  logic signed [SumW-1:0] sum_d [NumCh];
  logic signed [SumW-1:0] sum_q [NumCh];
  logic [PosW-1:0]        orow_q, ocol_q;

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      sum_d[ch] = SumW'(colsum[0][ch]) + SumW'(colsum[1][ch]) + SumW'(colsum[2][ch]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out && v4_q) begin
      sum_q  <= sum_d;
      orow_q <= orow4_q;
      ocol_q <= ocol4_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.sum0    = sum_q[0];
  assign out_o.sum1    = sum_q[1];
  assign out_o.sum2    = sum_q[2];
  assign out_o.out_row = orow_q;
  assign out_o.out_col = ocol_q;

endmodule

### rtl/rgbc3_linebuf.sv
// ----------------------------------------------------------------------------
// rgbc3_linebuf: two-row line store
// One entry per column holds the pixels of the two previous rows.
// ----------------------------------------------------------------------------
module rgbc3_linebuf (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [rgbc3_pkg::ColW-1:0] rd_addr_i,
  output rgbc3_pkg::line_t       rd_data_o,
  input  logic                   wr_en_i,
  input  logic [rgbc3_pkg::ColW-1:0] wr_addr_i,
  input  rgbc3_pkg::line_t       wr_data_i
);
  import rgbc3_pkg::*;

  line_t mem_q [MaxWidth];
  line_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

### rtl/rgbc3_cell.sv
// ----------------------------------------------------------------------------
// rgbc3_cell: one window column
// Holds one column of the 3x3 window, passes it to its neighbour on a
// shift and forms the registered column sums for all three channels.
// ----------------------------------------------------------------------------
module rgbc3_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rgbc3_pkg::cell_ctrl_t    ctrl_i,
  input  rgbc3_pkg::col_t          col_i,
  input  rgbc3_pkg::coef_col_t     coef_i,
  output rgbc3_pkg::col_t          col_o,
  output rgbc3_pkg::colsum_vec_t   colsum_o
);
  import rgbc3_pkg::*;

  col_t        col_q;
  prod_t       prod_d [NumRows][NumCh];
  prod_t       prod_q [NumRows][NumCh];
  colsum_vec_t sum_d;
  colsum_vec_t sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (ctrl_i.adv && ctrl_i.shift) begin
      col_q <= col_i;
    end
  end

  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      for (int ch = 0; ch < NumCh; ch++) begin
        prod_d[r][ch] = $signed({1'b0, col_q[r][ch]}) * $signed(coef_i[r]);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      sum_d[ch] = ColSumW'(prod_q[0][ch]) + ColSumW'(prod_q[1][ch])
                + ColSumW'(prod_q[2][ch]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      prod_q <= prod_d;
      sum_q  <= sum_d;
    end
  end

  assign col_o    = col_q;
  assign colsum_o = sum_q;

endmodule

### rtl/rgbc3_checker.sv
// ----------------------------------------------------------------------------
// rgbc3_checker: port-level checks of the 3x3 rgb convolution
// Flow control, held results and result ranges, bound to the top level.
// ----------------------------------------------------------------------------
module rgbc3_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic signed [rgbc3_pkg::SumW-1:0] sum0_i,
  input logic signed [rgbc3_pkg::SumW-1:0] sum1_i,
  input logic signed [rgbc3_pkg::SumW-1:0] sum2_i,
  input logic [rgbc3_pkg::PosW-1:0]    out_row_i,
  input logic [rgbc3_pkg::PosW-1:0]    out_col_i
);
  import rgbc3_pkg::*;

  localparam logic signed [SumW-1:0] SumHi = SumW'(SumBoundInt);
  localparam logic signed [SumW-1:0] SumLo = -SumHi;

  // handshake lines stay known once out of reset
  a_ctrl_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_valid_i, in_ready_i, out_valid_i, out_ready_i}))
    else $error("handshake signal unknown");

  // an empty or draining output register never holds back a request
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input stalled with free output register");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(sum0_i) && $stable(sum1_i)
      && $stable(sum2_i) && $stable(out_row_i) && $stable(out_col_i)))
    else $error("stalled result changed");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_row_i <= PosW'(PosMax) && out_col_i <= PosW'(PosMax)))
    else $error("result position beyond frame");

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (sum0_i <= SumHi && sum0_i >= SumLo && sum1_i <= SumHi
      && sum1_i >= SumLo && sum2_i <= SumHi && sum2_i >= SumLo))
    else $error("window sum out of range");

endmodule

bind rgb_conv3x3_valid rgbc3_checker u_rgbc3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .sum0_i      (out_o.sum0),
  .sum1_i      (out_o.sum1),
  .sum2_i      (out_o.sum2),
  .out_row_i   (out_o.out_row),
  .out_col_i   (out_o.out_col)
);
